// ===== rtl/wnrb_pkg.sv =====
`timescale 1ns / 1ps
// shared types, codes and default sizes for the windowed n-gram repeat ban
// no dependencies

package wnrb_pkg;

  localparam int MaxWindow    = 64;
  localparam int TokenBits    = 18;
  localparam int MaxNgram     = 8;
  localparam int MaxResults   = 64;
  localparam int VocabBits    = 19;
  localparam int CfgDataBits  = 19;
  localparam int CfgIndexBits = 2;

  localparam logic [3:0]           NgramReset  = 4'd3;
  localparam logic [6:0]           WindowReset = 7'd64;
  localparam logic [VocabBits-1:0] VocabReset  = 19'd262144;

  typedef enum logic [CfgIndexBits-1:0] {
    CFG_ENABLE = 2'd0,
    CFG_NGRAM  = 2'd1,
    CFG_WINDOW = 2'd2,
    CFG_VOCAB  = 2'd3
  } cfg_index_e;

  typedef enum logic [1:0] {
    STATUS_NONE     = 2'd0,
    STATUS_BANNED   = 2'd1,
    STATUS_REJECTED = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    KIND_REJECT = 2'd0,
    KIND_PASS   = 2'd1,
    KIND_SCAN   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    BK_IDLE  = 3'd0,
    BK_PUSH  = 3'd1,
    BK_START = 3'd2,
    BK_SCAN  = 3'd3,
    BK_DONE  = 3'd4
  } back_state_e;

  typedef struct packed {
    logic                 enable;
    logic [3:0]           ngram_size;
    logic [6:0]           window_length;
    logic [VocabBits-1:0] vocab_limit;
  } cfg_t;

endpackage

// ===== rtl/windowed_ngram_repeat_ban.sv =====
`timescale 1ns / 1ps
// top level of the windowed n-gram repeat ban: config registers, front end, back end
// depends on wnrb_pkg, wnrb_front, wnrb_back (and wnrb_ram below it)
//
// channel   dir  handshake                  payload
// in        in   in_valid_i / in_stall_o    token_i
// out       out  out_valid_o / out_stall_i  status_o, banned_token_o, last_o
// cfg       in   cfg_we_i (no wait)         cfg_index_i, cfg_data_i
//
// a rejected or pass-through token loads its one result from idle, once the output is free
// a scanned token is pushed, then c = min(tokens pushed, window) history entries are read
// through the single read port, one a cycle while no ban is held; none if c is below n
// reset needs no clearing pass: only written history entries are ever inside the window
// the front queue holds two tokens, so input can run ahead of a scan until it is full
// an output stall freezes the scan only when a second ban must leave

module windowed_ngram_repeat_ban #(
  parameter int MAX_WINDOW = wnrb_pkg::MaxWindow,
  parameter int TOKEN_BITS = wnrb_pkg::TokenBits,
  parameter int MAX_NGRAM  = wnrb_pkg::MaxNgram
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // token requests
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [TOKEN_BITS-1:0]             token_i,
  // ban results
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [1:0]                        status_o,
  output logic [TOKEN_BITS-1:0]             banned_token_o,
  output logic                              last_o,
  // register writes
  input  logic                              cfg_we_i,
  input  logic [wnrb_pkg::CfgIndexBits-1:0] cfg_index_i,
  input  logic [wnrb_pkg::CfgDataBits-1:0]  cfg_data_i
);

  wnrb_pkg::cfg_t        cfg_q, cfg_d;
  logic                  q_valid;
  wnrb_pkg::kind_e       q_kind;
  logic [TOKEN_BITS-1:0] q_token;
  logic                  q_pop;

  // register file, each write keeps only the register's own width
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (wnrb_pkg::cfg_index_e'(cfg_index_i))
        wnrb_pkg::CFG_ENABLE: cfg_d.enable        = cfg_data_i[0];
        wnrb_pkg::CFG_NGRAM:  cfg_d.ngram_size    = cfg_data_i[3:0];
        wnrb_pkg::CFG_WINDOW: cfg_d.window_length = cfg_data_i[6:0];
        wnrb_pkg::CFG_VOCAB:  cfg_d.vocab_limit   = cfg_data_i[wnrb_pkg::VocabBits-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable        <= 1'b0;
      cfg_q.ngram_size    <= wnrb_pkg::NgramReset;
      cfg_q.window_length <= wnrb_pkg::WindowReset;
      cfg_q.vocab_limit   <= wnrb_pkg::VocabReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // classification and queueing of incoming tokens
  wnrb_front #(
    .TOKEN_BITS (TOKEN_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .token_i    (token_i),
    .q_valid_o  (q_valid),
    .q_kind_o   (q_kind),
    .q_token_o  (q_token),
    .q_pop_i    (q_pop)
  );

  // history push, window scan and result register
  wnrb_back #(
    .MAX_WINDOW (MAX_WINDOW),
    .TOKEN_BITS (TOKEN_BITS),
    .MAX_NGRAM  (MAX_NGRAM)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .q_valid_i      (q_valid),
    .q_kind_i       (q_kind),
    .q_token_i      (q_token),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .banned_token_o (banned_token_o),
    .last_o         (last_o)
  );

endmodule

// ===== rtl/wnrb_ram.sv =====
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read
// no dependencies

module wnrb_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/wnrb_front.sv =====
`timescale 1ns / 1ps
// front end: takes tokens, classifies them and holds them in a two-entry queue
// depends on wnrb_pkg

module wnrb_front #(
  parameter int TOKEN_BITS = wnrb_pkg::TokenBits
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  wnrb_pkg::cfg_t        cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [TOKEN_BITS-1:0] token_i,
  output logic                  q_valid_o,
  output wnrb_pkg::kind_e       q_kind_o,
  output logic [TOKEN_BITS-1:0] q_token_o,
  input  logic                  q_pop_i
);

  localparam int VW = (TOKEN_BITS > wnrb_pkg::VocabBits) ? TOKEN_BITS : wnrb_pkg::VocabBits;

  wnrb_pkg::kind_e       kind_q [2];
  logic [TOKEN_BITS-1:0] tok_q  [2];
  logic                  wptr_q, wptr_d;
  logic                  rptr_q, rptr_d;
  logic [1:0]            count_q, count_d;
  logic                  push, pop;
  wnrb_pkg::kind_e       kind;

  // reject test runs even when disabled
  always_comb begin
    if (VW'(token_i) >= VW'(cfg_i.vocab_limit)) begin
      kind = wnrb_pkg::KIND_REJECT;
    end else if (!cfg_i.enable) begin
      kind = wnrb_pkg::KIND_PASS;
    end else begin
      kind = wnrb_pkg::KIND_SCAN;
    end
  end

  assign in_stall_o = (count_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = q_pop_i && (count_q != 2'd0);
  assign q_valid_o  = (count_q != 2'd0);
  assign q_kind_o   = kind_q[rptr_q];
  assign q_token_o  = tok_q[rptr_q];

  always_comb begin
    wptr_d  = push ? ~wptr_q : wptr_q;
    rptr_d  = pop ? ~rptr_q : rptr_q;
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      kind_q[wptr_q] <= kind;
      tok_q[wptr_q]  <= token_i;
    end
  end

endmodule

// ===== rtl/wnrb_back.sv =====
`timescale 1ns / 1ps
// back end: history ring, window scan against the newest n-1 tokens, result register
// depends on wnrb_pkg and wnrb_ram

module wnrb_back #(
  parameter int MAX_WINDOW = wnrb_pkg::MaxWindow,
  parameter int TOKEN_BITS = wnrb_pkg::TokenBits,
  parameter int MAX_NGRAM  = wnrb_pkg::MaxNgram
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  wnrb_pkg::cfg_t        cfg_i,
  input  logic                  q_valid_i,
  input  wnrb_pkg::kind_e       q_kind_i,
  input  logic [TOKEN_BITS-1:0] q_token_i,
  output logic                  q_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            status_o,
  output logic [TOKEN_BITS-1:0] banned_token_o,
  output logic                  last_o
);

  localparam int AW = $clog2(MAX_WINDOW);
  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int EW = (CW > 7) ? CW : 7;
  localparam int SL = (MAX_NGRAM > 1) ? MAX_NGRAM - 1 : 1;
  localparam int RW = $clog2(wnrb_pkg::MaxResults + 1);

  wnrb_pkg::back_state_e state_q, state_d;
  logic [TOKEN_BITS-1:0] cur_tok_q, cur_tok_d;
  logic [AW-1:0]         slot_q, slot_d, slot_nx;
  logic [CW-1:0]         pc_q, pc_d, pc_nx;
  logic [TOKEN_BITS-1:0] sfx_q [SL];
  logic [TOKEN_BITS-1:0] sfx_d [SL];
  logic [TOKEN_BITS-1:0] pw_q  [SL];
  logic [TOKEN_BITS-1:0] pw_d  [SL];
  logic [CW-1:0]         c_q, c_d;
  logic [AW-1:0]         addr_q, addr_d, addr_nx;
  logic [CW-1:0]         left_q, left_d;
  logic [CW-1:0]         seen_q, seen_d;
  logic                  dv_q, dv_d;
  logic                  pend_valid_q, pend_valid_d;
  logic [TOKEN_BITS-1:0] pend_tok_q, pend_tok_d;
  logic [RW-1:0]         cnt_q, cnt_d;
  logic                  out_valid_q, out_valid_d;
  wnrb_pkg::status_e     out_status_q;
  logic [TOKEN_BITS-1:0] out_tok_q;
  logic                  out_last_q;

  logic                  emit, emit_last, out_free;
  wnrb_pkg::status_e     emit_status;
  logic [TOKEN_BITS-1:0] emit_tok;
  logic                  ram_we, ram_re;
  logic [TOKEN_BITS-1:0] rdata;
  logic [EW-1:0]         ng_e, win_e, n1, w1, w2, n2;
  logic [CW-1:0]         n_eff, w_eff, nm1;
  logic [CW:0]           slot_x, start_x;
  logic                  eq, match, hold;

  // effective n and window from the live registers
  always_comb begin
    ng_e  = EW'(cfg_i.ngram_size);
    win_e = EW'(cfg_i.window_length);
    if (ng_e == '0) begin
      n1 = EW'(1);
    end else if (ng_e > EW'(MAX_NGRAM)) begin
      n1 = EW'(MAX_NGRAM);
    end else begin
      n1 = ng_e;
    end
    w1 = (win_e < n1) ? n1 : win_e;
    w2 = (w1 > EW'(MAX_WINDOW)) ? EW'(MAX_WINDOW) : w1;
    n2 = (n1 > w2) ? w2 : n1;
  end

  assign n_eff = CW'(n2);
  assign w_eff = CW'(w2);
  assign nm1   = n_eff - CW'(1);

  assign slot_nx = (slot_q == AW'(MAX_WINDOW - 1)) ? '0 : slot_q + AW'(1);
  assign addr_nx = (addr_q == AW'(MAX_WINDOW - 1)) ? '0 : addr_q + AW'(1);
  assign pc_nx   = (pc_q == CW'(MAX_WINDOW)) ? pc_q : pc_q + CW'(1);

  // oldest window slot, ring wraps at the full depth
  always_comb begin
    slot_x = (CW+1)'(slot_q);
    if (slot_x >= (CW+1)'(c_q)) begin
      start_x = slot_x - (CW+1)'(c_q);
    end else begin
      start_x = slot_x + (CW+1)'(MAX_WINDOW) - (CW+1)'(c_q);
    end
  end

  // prefix of the entry under test against the newest n-1 tokens
  always_comb begin
    eq = 1'b1;
    for (int j = 0; j < SL; j++) begin
      if ((EW'(j) < EW'(nm1)) && (pw_q[j] != sfx_q[j])) begin
        eq = 1'b0;
      end
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign match    = dv_q && (seen_q >= nm1) && eq && (cnt_q < RW'(wnrb_pkg::MaxResults));
  assign hold     = match && pend_valid_q && !out_free;

  always_comb begin
    state_d      = state_q;
    cur_tok_d    = cur_tok_q;
    slot_d       = slot_q;
    pc_d         = pc_q;
    sfx_d        = sfx_q;
    pw_d         = pw_q;
    c_d          = c_q;
    addr_d       = addr_q;
    left_d       = left_q;
    seen_d       = seen_q;
    dv_d         = dv_q;
    pend_valid_d = pend_valid_q;
    pend_tok_d   = pend_tok_q;
    cnt_d        = cnt_q;
    q_pop_o      = 1'b0;
    emit         = 1'b0;
    emit_status  = wnrb_pkg::STATUS_NONE;
    emit_tok     = '0;
    emit_last    = 1'b1;
    ram_we       = 1'b0;
    ram_re       = 1'b0;

    unique case (state_q)
      wnrb_pkg::BK_IDLE: begin
        if (q_valid_i) begin
          if (q_kind_i == wnrb_pkg::KIND_SCAN) begin
            q_pop_o   = 1'b1;
            cur_tok_d = q_token_i;
            state_d   = wnrb_pkg::BK_PUSH;
          end else if (out_free) begin
            q_pop_o     = 1'b1;
            emit        = 1'b1;
            emit_status = (q_kind_i == wnrb_pkg::KIND_REJECT) ?
                          wnrb_pkg::STATUS_REJECTED : wnrb_pkg::STATUS_NONE;
          end
        end
      end
      wnrb_pkg::BK_PUSH: begin
        ram_we   = 1'b1;
        slot_d   = slot_nx;
        pc_d     = pc_nx;
        sfx_d[0] = cur_tok_q;
        for (int j = 1; j < SL; j++) begin
          sfx_d[j] = sfx_q[j-1];
        end
        c_d     = (pc_nx < w_eff) ? pc_nx : w_eff;
        state_d = wnrb_pkg::BK_START;
      end
      wnrb_pkg::BK_START: begin
        if (c_q < n_eff) begin
          if (out_free) begin
            emit    = 1'b1;
            state_d = wnrb_pkg::BK_IDLE;
          end
        end else begin
          addr_d       = AW'(start_x);
          left_d       = c_q;
          seen_d       = '0;
          dv_d         = 1'b0;
          cnt_d        = '0;
          pend_valid_d = 1'b0;
          state_d      = wnrb_pkg::BK_SCAN;
        end
      end
      wnrb_pkg::BK_SCAN: begin
        if (!hold) begin
          if (dv_q) begin
            pw_d[0] = rdata;
            for (int j = 1; j < SL; j++) begin
              pw_d[j] = pw_q[j-1];
            end
            seen_d = seen_q + CW'(1);
            if (match) begin
              if (pend_valid_q) begin
                emit        = 1'b1;
                emit_status = wnrb_pkg::STATUS_BANNED;
                emit_tok    = pend_tok_q;
                emit_last   = 1'b0;
              end
              pend_valid_d = 1'b1;
              pend_tok_d   = rdata;
              cnt_d        = cnt_q + RW'(1);
            end
          end
          ram_re = (left_q != '0);
          if (ram_re) begin
            addr_d = addr_nx;
            left_d = left_q - CW'(1);
          end
          dv_d = ram_re;
          if (!dv_q && (left_q == '0)) begin
            state_d = wnrb_pkg::BK_DONE;
          end
        end
      end
      wnrb_pkg::BK_DONE: begin
        if (out_free) begin
          emit = 1'b1;
          if (pend_valid_q) begin
            emit_status = wnrb_pkg::STATUS_BANNED;
            emit_tok    = pend_tok_q;
          end
          pend_valid_d = 1'b0;
          state_d      = wnrb_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = wnrb_pkg::BK_IDLE;
      end
    endcase
  end

  assign out_valid_d = emit ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= wnrb_pkg::BK_IDLE;
      slot_q       <= '0;
      pc_q         <= '0;
      left_q       <= '0;
      seen_q       <= '0;
      dv_q         <= 1'b0;
      pend_valid_q <= 1'b0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      slot_q       <= slot_d;
      pc_q         <= pc_d;
      left_q       <= left_d;
      seen_q       <= seen_d;
      dv_q         <= dv_d;
      pend_valid_q <= pend_valid_d;
      cnt_q        <= cnt_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_tok_q  <= cur_tok_d;
    sfx_q      <= sfx_d;
    pw_q       <= pw_d;
    c_q        <= c_d;
    addr_q     <= addr_d;
    pend_tok_q <= pend_tok_d;
    if (emit) begin
      out_status_q <= emit_status;
      out_tok_q    <= emit_tok;
      out_last_q   <= emit_last;
    end
  end

  wnrb_ram #(
    .WIDTH (TOKEN_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (cur_tok_q),
    .re_i    (ram_re),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign banned_token_o = out_tok_q;
  assign last_o         = out_last_q;

  // only bans can be followed by more results of the same token
  a_not_last_is_ban: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_last_q |-> out_status_q == wnrb_pkg::STATUS_BANNED)
    else $error("non-final result is not a ban");

  // nothing left over from a scan once back in idle
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == wnrb_pkg::BK_IDLE |-> !pend_valid_q && !dv_q)
    else $error("scan state left over in idle");

  // a held ban never gets lost while the result register is stalled
  a_hold_keeps_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == wnrb_pkg::BK_SCAN && hold |=> pend_valid_q && $stable(pend_tok_q))
    else $error("pending ban lost during stall");

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= RW'(wnrb_pkg::MaxResults))
    else $error("result count above cap");

endmodule
